// ===== rtl/core/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, codes and types of the least-frequently-used cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES   = 8;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 16;
    localparam int OCC_W     = $clog2(ENTRIES + 1);
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_SET = 1'b1
    } action_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic              lookup;
        logic              upd_hit;
        logic              upd_ins;
        logic [KEY_W-1:0]  look_key;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  mov_value;
        logic [CNT_W-1:0]  mov_count;
        logic [VAL_W-1:0]  ins_value;
        logic [CNT_W-1:0]  ins_count;
    } cell_ctl_t;

endpackage

// ===== rtl/core/lfu_cell.sv =====
// ----------------------------------------------------------------------------
// lfu_cell
// One rank slot: holds key, value and count, compares the lookup key, and
// moves its entry down the rank when a hit entry is promoted past it.
// ----------------------------------------------------------------------------
module lfu_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lfu_pkg::cell_ctl_t         ctl,
    input  logic                       in_use,
    input  logic                       ins_sel,
    input  logic                       prev_blk_in,
    input  logic                       pos_in,
    input  logic                       blk_in,
    input  logic [lfu_pkg::KEY_W-1:0]  up_key,
    input  logic [lfu_pkg::VAL_W-1:0]  up_value,
    input  logic [lfu_pkg::CNT_W-1:0]  up_count,
    output logic                       pos_out,
    output logic                       blk_out,
    output logic                       match_now,
    output logic                       match,
    output logic [lfu_pkg::KEY_W-1:0]  key,
    output logic [lfu_pkg::VAL_W-1:0]  value,
    output logic [lfu_pkg::CNT_W-1:0]  count
);

    logic [lfu_pkg::KEY_W-1:0] key_reg,   key_next;
    logic [lfu_pkg::VAL_W-1:0] value_reg, value_next;
    logic [lfu_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      match_reg, match_next;
    logic                      pos_self;
    logic                      blk_self;
    logic                      take;
    logic                      shift;

    assign match_now = ctl.lookup && in_use && (key_reg == ctl.look_key);
    assign match_next = ctl.lookup ? match_now : match_reg;

    // pos_self: the hit entry sits here or further toward the tail
    assign pos_self = match_reg | pos_in;
    assign pos_out  = pos_self;
    // an earlier entry with a higher count stops the promotion
    assign blk_self = pos_in && (count_reg > ctl.mov_count);
    assign blk_out  = blk_in | blk_self;

    assign take  = ctl.upd_hit && pos_self && !blk_out && prev_blk_in;
    assign shift = ctl.upd_hit && pos_self && !prev_blk_in;

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        if (take) begin
            key_next   = ctl.key;
            value_next = ctl.mov_value;
            count_next = ctl.mov_count;
        end else if (shift) begin
            key_next   = up_key;
            value_next = up_value;
            count_next = up_count;
        end else if (ctl.upd_ins && ins_sel) begin
            key_next   = ctl.key;
            value_next = ctl.ins_value;
            count_next = ctl.ins_count;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign count = count_reg;

endmodule

// ===== rtl/core/lfu_cache.sv =====
// ----------------------------------------------------------------------------
// lfu_cache
// Key-value cache with least-frequently-used replacement over a rank chain.
// ----------------------------------------------------------------------------
// result: registered from the rank update state that follows the item's acceptance
// each item has a lookup, then a rank update; no new item is accepted during the update
// a result held by m_tready low stalls the next item until it is taken
// the promotion of a hit entry past lower counts is done by every cell at once
// reset: occupancy and control cleared, cell contents undefined until written
module lfu_cache (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // lookup_key, write_value, init_count
    input  logic [lfu_pkg::S_DATA_W-1:0]  s_tdata,
    // action
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value, evicted_key
    output logic [lfu_pkg::M_DATA_W-1:0]  m_tdata,
    // hit, evicted
    output logic [1:0]                    m_tuser
);

    localparam int E = lfu_pkg::ENTRIES;

    lfu_pkg::state_t                 state_reg, state_next;
    logic [lfu_pkg::OCC_W-1:0]       occ_reg, occ_next;
    lfu_pkg::action_t                act_reg, act_next;
    logic [lfu_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [lfu_pkg::VAL_W-1:0]       wval_reg, wval_next;
    logic [lfu_pkg::CNT_W-1:0]       icnt_reg, icnt_next;
    logic                            hit_reg, hit_next;
    logic [lfu_pkg::VAL_W-1:0]       selv_reg, selv_next;
    logic [lfu_pkg::CNT_W-1:0]       newc_reg, newc_next;
    logic                            m_valid_reg, m_valid_next;
    logic [lfu_pkg::M_DATA_W-1:0]    m_data_reg, m_data_next;
    logic [1:0]                      m_user_reg, m_user_next;

    logic                            accept;
    logic                            full;
    lfu_pkg::cell_ctl_t              ctl;
    logic [lfu_pkg::VAL_W-1:0]       selv_comb;
    logic [lfu_pkg::CNT_W-1:0]       selc_comb;
    logic [lfu_pkg::KEY_W-1:0]       evict_key;

    logic [E-1:0]                    in_use;
    logic [E-1:0]                    ins_sel;
    logic [E-1:0]                    match_now;
    logic [E-1:0]                    match_vec;
    logic [E:0]                      pos_chain;
    logic [E:0]                      blk_chain;
    logic [lfu_pkg::KEY_W-1:0]       cell_key   [E];
    logic [lfu_pkg::VAL_W-1:0]       cell_value [E];
    logic [lfu_pkg::CNT_W-1:0]       cell_count [E];

    assign full   = (occ_reg == lfu_pkg::OCC_W'(E));
    assign accept = s_tvalid && s_tready;

    assign pos_chain[E] = 1'b0;
    assign blk_chain[E] = 1'b0;

    genvar j;
    generate
        for (j = 0; j < E; j++) begin : g_cell
            logic                      prev_blk;
            logic [lfu_pkg::KEY_W-1:0] up_key;
            logic [lfu_pkg::VAL_W-1:0] up_value;
            logic [lfu_pkg::CNT_W-1:0] up_count;

            assign in_use[j]  = (lfu_pkg::OCC_W'(j) < occ_reg);
            assign ins_sel[j] = full ? (j == E - 1) : (lfu_pkg::OCC_W'(j) == occ_reg);

            if (j == 0) begin : g_head
                assign prev_blk = 1'b1;
                assign up_key   = '0;
                assign up_value = '0;
                assign up_count = '0;
            end else begin : g_body
                assign prev_blk = blk_chain[j-1];
                assign up_key   = cell_key[j-1];
                assign up_value = cell_value[j-1];
                assign up_count = cell_count[j-1];
            end

            lfu_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .in_use      (in_use[j]),
                .ins_sel     (ins_sel[j]),
                .prev_blk_in (prev_blk),
                .pos_in      (pos_chain[j+1]),
                .blk_in      (blk_chain[j+1]),
                .up_key      (up_key),
                .up_value    (up_value),
                .up_count    (up_count),
                .pos_out     (pos_chain[j]),
                .blk_out     (blk_chain[j]),
                .match_now   (match_now[j]),
                .match       (match_vec[j]),
                .key         (cell_key[j]),
                .value       (cell_value[j]),
                .count       (cell_count[j])
            );
        end
    endgenerate

    assign evict_key = cell_key[E-1];

    always_comb begin
        selv_comb = '0;
        selc_comb = '0;
        for (int i = 0; i < E; i++) begin
            if (match_now[i]) begin
                selv_comb = selv_comb | cell_value[i];
                selc_comb = selc_comb | cell_count[i];
            end
        end
    end

    always_comb begin
        ctl.lookup    = accept;
        ctl.upd_hit   = (state_reg == lfu_pkg::ST_UPDATE) && hit_reg;
        ctl.upd_ins   = (state_reg == lfu_pkg::ST_UPDATE) && !hit_reg
                        && (act_reg == lfu_pkg::ACT_SET);
        ctl.look_key  = s_tdata[31:0];
        ctl.key       = key_reg;
        ctl.mov_value = (act_reg == lfu_pkg::ACT_SET) ? wval_reg : selv_reg;
        ctl.mov_count = newc_reg;
        ctl.ins_value = wval_reg;
        ctl.ins_count = icnt_reg;
    end

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        wval_next    = wval_reg;
        icnt_next    = icnt_reg;
        hit_next     = hit_reg;
        selv_next    = selv_reg;
        newc_next    = newc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        s_tready     = 1'b0;
        case (state_reg)
            lfu_pkg::ST_IDLE: begin
                s_tready = !m_valid_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    act_next   = lfu_pkg::action_t'(s_tuser[0]);
                    key_next   = s_tdata[31:0];
                    wval_next  = s_tdata[63:32];
                    icnt_next  = s_tdata[79:64];
                    hit_next   = |match_now;
                    selv_next  = selv_comb;
                    newc_next  = (selc_comb == lfu_pkg::COUNT_MAX) ? selc_comb
                                                                   : selc_comb + 1'b1;
                    state_next = lfu_pkg::ST_UPDATE;
                end
            end
            lfu_pkg::ST_UPDATE: begin
                m_valid_next = 1'b1;
                m_user_next  = 2'b00;
                m_data_next  = '0;
                if (hit_reg) begin
                    m_user_next[0] = 1'b1;
                    if (act_reg == lfu_pkg::ACT_GET) begin
                        m_data_next[31:0] = selv_reg;
                    end
                end else if (act_reg == lfu_pkg::ACT_SET) begin
                    if (full) begin
                        m_user_next[1]     = 1'b1;
                        m_data_next[63:32] = evict_key;
                    end else begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
                state_next = lfu_pkg::ST_IDLE;
            end
            default: begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        wval_reg   <= wval_next;
        icnt_reg   <= icnt_next;
        hit_reg    <= hit_next;
        selv_reg   <= selv_next;
        newc_reg   <= newc_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        if (!aresetn) begin
            state_reg   <= lfu_pkg::ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= lfu_pkg::OCC_W'(E))
        else $error("occupancy above capacity");

    a_unique_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfu_pkg::ST_UPDATE) |-> $onehot0(match_vec))
        else $error("key present in more than one cell");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == lfu_pkg::ST_UPDATE) && !hit_reg
         && (act_reg == lfu_pkg::ACT_SET) && full)
        |=> (m_tvalid && m_tuser[1] && occ_reg == lfu_pkg::OCC_W'(E)))
        else $error("set miss on full cache did not evict");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfu_pkg::ST_UPDATE) |-> !s_tready)
        else $error("item accepted during rank update");

endmodule
